### rtl/ordered_list_table_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list table engine
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLTE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("olte: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OLTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("olte: next-cycle check failed");

`endif

### rtl/olte_pkg.sv
// ----------------------------------------------------------------------------
// olte_pkg
// Types and fixed constants of the ordered list table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olte_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned OP_W  = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 5;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_AT   = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_AT   = 3'd5,
    OP_SEARCH   = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_INS,
    KIND_DEL,
    KIND_SRCH,
    KIND_NOP
  } kind_e;

  typedef enum logic [1:0] {
    WHERE_HEAD,
    WHERE_TAIL,
    WHERE_POS
  } where_e;

  typedef struct packed {
    kind_e              kind;
    where_e             where;
    logic [POS_W-1:0]   position;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_INS_STEP,
    BK_INS_MOVE,
    BK_DEL_TAKE,
    BK_DEL_STEP,
    BK_DEL_MOVE,
    BK_SRCH_CMP
  } back_state_e;

endpackage

`default_nettype wire

### rtl/olte_if.sv
// ----------------------------------------------------------------------------
// olte channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface olte_req_if import olte_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, operation, value, position, input ready);
  modport sink   (input valid, operation, value, position, output ready);
endinterface

interface olte_rsp_if import olte_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] removed_value;
  logic [CNT_W-1:0]        found_position;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, status, removed_value, found_position, entry_count,
                  input ready);
  modport sink   (input valid, status, removed_value, found_position, entry_count,
                  output ready);
endinterface

`default_nettype wire

### rtl/olte_front.sv
// ----------------------------------------------------------------------------
// olte_front
// Decodes a request into a command class and resizes the value word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olte_front
  import olte_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic [OP_W-1:0]         operation_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic [POS_W-1:0]        position_i,
  output cmd_t                         cmd_o,
  output logic [VALUE_WIDTH-1:0]       value_o
);

  // sign extend or truncate to the stored word width
  assign value_o = VALUE_WIDTH'(value_i);

  always_comb begin
    cmd_o.position = position_i;
    cmd_o.kind     = KIND_NOP;
    cmd_o.where    = WHERE_HEAD;
    case (operation_i)
      OP_INS_HEAD: begin
        cmd_o.kind  = KIND_INS;
        cmd_o.where = WHERE_HEAD;
      end
      OP_INS_TAIL: begin
        cmd_o.kind  = KIND_INS;
        cmd_o.where = WHERE_TAIL;
      end
      OP_INS_AT: begin
        cmd_o.kind  = KIND_INS;
        cmd_o.where = WHERE_POS;
      end
      OP_DEL_HEAD: begin
        cmd_o.kind  = KIND_DEL;
        cmd_o.where = WHERE_HEAD;
      end
      OP_DEL_TAIL: begin
        cmd_o.kind  = KIND_DEL;
        cmd_o.where = WHERE_TAIL;
      end
      OP_DEL_AT: begin
        cmd_o.kind  = KIND_DEL;
        cmd_o.where = WHERE_POS;
      end
      OP_SEARCH: begin
        cmd_o.kind  = KIND_SRCH;
      end
      default: begin
        cmd_o.kind  = KIND_NOP;  // unused code: item is ignored
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/olte_queue.sv
// ----------------------------------------------------------------------------
// olte_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olte_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  wire logic [W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_ready_i,
  output logic [W-1:0]      pop_data_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q, cnt_d;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/olte_back.sv
// ----------------------------------------------------------------------------
// olte_back
// Executes list commands on the entry memory and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olte_back
  import olte_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cmd_valid_i,
  input  wire cmd_t                   cmd_i,
  input  wire logic [VALUE_WIDTH-1:0] cmd_value_i,
  output logic                        cmd_pop_o,
  input  wire logic                   rsp_ready_i,
  output logic                        rsp_valid_o,
  output logic [ST_W-1:0]             rsp_status_o,
  output logic signed [VAL_W-1:0]     rsp_removed_o,
  output logic [CNT_W-1:0]            rsp_found_o,
  output logic [CNT_W-1:0]            rsp_count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = ((LW > POS_W) ? LW : POS_W) + 1;

  back_state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] idx_q, idx_d, at_q, at_d, at_c;
  logic [VALUE_WIDTH-1:0] val_q, val_d, removed_q, removed_d;

  // entry memory, one write and one registered read port
  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  logic                   fin;
  status_e                fin_status;
  logic [VALUE_WIDTH-1:0] fin_removed;
  logic [CNT_W-1:0]       fin_found;
  logic [LW-1:0]          fin_count;

  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q;
  logic signed [VAL_W-1:0] out_removed_q;
  logic [CNT_W-1:0]       out_found_q, out_count_q;

  logic [CW-1:0] pos_c, len_c;
  logic          out_free;

  assign pos_c    = CW'(cmd_i.position);
  assign len_c    = CW'(len_q);
  assign out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    at_d        = at_q;
    at_c        = '0;
    val_d       = val_q;
    removed_d   = removed_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = rdata_q;
    mem_re      = 1'b0;
    mem_raddr   = idx_q;
    cmd_pop_o   = 1'b0;
    fin         = 1'b0;
    fin_status  = ST_OK;
    fin_removed = '0;
    fin_found   = '0;
    fin_count   = len_q;

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          val_d     = cmd_value_i;
          case (cmd_i.kind)
            KIND_INS: begin
              case (cmd_i.where)
                WHERE_HEAD: at_c = '0;
                WHERE_TAIL: at_c = AW'(len_q);
                default:    at_c = AW'(pos_c - CW'(1));
              endcase
              if (len_q == LW'(DEPTH)) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else if (cmd_i.where == WHERE_POS &&
                           (pos_c == '0 || pos_c > len_c + CW'(1))) begin
                fin        = 1'b1;
                fin_status = ST_BADPOS;
              end else begin
                idx_d   = AW'(len_q);
                at_d    = at_c;
                state_d = BK_INS_STEP;
              end
            end
            KIND_DEL: begin
              case (cmd_i.where)
                WHERE_HEAD: at_c = '0;
                WHERE_TAIL: at_c = AW'(len_c - CW'(1));
                default:    at_c = AW'(pos_c - CW'(1));
              endcase
              if (len_q == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else if (cmd_i.where == WHERE_POS &&
                           (pos_c == '0 || pos_c > len_c)) begin
                fin        = 1'b1;
                fin_status = ST_BADPOS;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = at_c;
                idx_d     = at_c;
                state_d   = BK_DEL_TAKE;
              end
            end
            KIND_SRCH: begin
              if (len_q == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_d     = '0;
                state_d   = BK_SRCH_CMP;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // walk from the tail down to the insert slot, each move a read then a write
      BK_INS_STEP: begin
        if (idx_q == at_q) begin
          mem_we    = 1'b1;
          mem_waddr = at_q;
          mem_wdata = val_q;
          len_d     = len_q + LW'(1);
          fin       = 1'b1;
          fin_count = len_d;
          state_d   = BK_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q - AW'(1);
          state_d   = BK_INS_MOVE;
        end
      end
      BK_INS_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rdata_q;
        idx_d     = idx_q - AW'(1);
        state_d   = BK_INS_STEP;
      end

      BK_DEL_TAKE: begin
        removed_d = rdata_q;
        state_d   = BK_DEL_STEP;
      end
      // close the gap toward the tail
      BK_DEL_STEP: begin
        if (LW'(idx_q) + LW'(1) >= len_q) begin
          len_d       = len_q - LW'(1);
          fin         = 1'b1;
          fin_removed = removed_q;
          fin_count   = len_d;
          state_d     = BK_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + AW'(1);
          state_d   = BK_DEL_MOVE;
        end
      end
      BK_DEL_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rdata_q;
        idx_d     = idx_q + AW'(1);
        state_d   = BK_DEL_STEP;
      end

      // compare one entry per cycle while the next read is in flight
      BK_SRCH_CMP: begin
        if (rdata_q == val_q) begin
          fin       = 1'b1;
          fin_found = CNT_W'(LW'(idx_q) + LW'(1));
          state_d   = BK_IDLE;
        end else if (LW'(idx_q) + LW'(1) == len_q) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
          state_d    = BK_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (fin) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    at_q      <= at_d;
    val_q     <= val_d;
    removed_q <= removed_d;
    if (fin) begin
      out_status_q  <= fin_status;
      out_removed_q <= VAL_W'(signed'(fin_removed));
      out_found_q   <= fin_found;
      out_count_q   <= CNT_W'(fin_count);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign rsp_valid_o   = out_valid_q;
  assign rsp_status_o  = out_status_q;
  assign rsp_removed_o = out_removed_q;
  assign rsp_found_o   = out_found_q;
  assign rsp_count_o   = out_count_q;

endmodule

`default_nettype wire

### rtl/ordered_list_table_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_table_engine
// Ordered list of up to DEPTH signed words with positional insert, delete
// and search.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command item: operation, value and 1-based position.
//   rsp_o returns exactly one item per command: status, removed word, first
//   matching position and the entry count after the command.
//   A two-entry queue sits between decode and execution, so up to two more
//   commands are taken while one executes; results wait in an output
//   register, and no new command is started while that register is held by
//   a stalled receiver.
//   Steps from acceptance to result, through the single read port of the
//   entry memory: a rejected or ignored command has its result registered
//   at acceptance; an insert reads and writes each entry it shifts back,
//   then writes the new word; a delete reads and takes the removed word,
//   then reads and writes each entry it shifts forward; a search compares
//   one entry per read.
//   Commands execute one at a time; the move loop sets the rate.
//   Reset empties the list at once; the memory itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_table_engine
  import olte_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  olte_req_if.sink    req_i,
  olte_rsp_if.source  rsp_o
);

  localparam int unsigned QW = $bits(cmd_t) + VALUE_WIDTH;

  // front end: decode
  cmd_t                   dec_cmd;
  logic [VALUE_WIDTH-1:0] dec_value;

  olte_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .operation_i (req_i.operation),
    .value_i     (req_i.value),
    .position_i  (req_i.position),
    .cmd_o       (dec_cmd),
    .value_o     (dec_value)
  );

  // decoupling queue
  logic          q_valid, q_pop;
  logic [QW-1:0] q_data;
  cmd_t          exe_cmd;
  logic [VALUE_WIDTH-1:0] exe_value;

  olte_queue #(
    .W (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (req_i.valid),
    .push_ready_o (req_i.ready),
    .push_data_i  ({dec_cmd, dec_value}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_pop),
    .pop_data_o   (q_data)
  );

  assign exe_cmd   = cmd_t'(q_data[QW-1:VALUE_WIDTH]);
  assign exe_value = q_data[VALUE_WIDTH-1:0];

  // back end: list execution and result register
  olte_back #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (exe_cmd),
    .cmd_value_i   (exe_value),
    .cmd_pop_o     (q_pop),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_status_o  (rsp_o.status),
    .rsp_removed_o (rsp_o.removed_value),
    .rsp_found_o   (rsp_o.found_position),
    .rsp_count_o   (rsp_o.entry_count)
  );

endmodule

`default_nettype wire

### rtl/olte_chk.sv
// ----------------------------------------------------------------------------
// olte_chk
// Port-level checks of the ordered list table engine, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_table_engine_assert.svh"

module olte_chk
  import olte_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    rsp_valid_i,
  input wire logic                    rsp_ready_i,
  input wire logic [ST_W-1:0]         rsp_status_i,
  input wire logic signed [VAL_W-1:0] rsp_removed_i,
  input wire logic [CNT_W-1:0]        rsp_found_i,
  input wire logic [CNT_W-1:0]        rsp_count_i
);

  // a stalled result holds
  `OLTE_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_removed_i) && $stable(rsp_count_i))

  // a failed command removes nothing and finds nothing
  `OLTE_ASSERT_NOW(a_fail_clean, clk_i, rst_ni, rsp_valid_i && rsp_status_i != ST_OK, rsp_removed_i == '0 && rsp_found_i == '0)

  // empty reports come with a zero count
  `OLTE_ASSERT_NOW(a_empty_count, clk_i, rst_ni, rsp_valid_i && rsp_status_i == ST_EMPTY, rsp_count_i == '0)

  // full reports come with a full count
  `OLTE_ASSERT_NOW(a_full_count, clk_i, rst_ni, rsp_valid_i && rsp_status_i == ST_FULL && DEPTH < 32, rsp_count_i == CNT_W'(DEPTH))

endmodule

bind ordered_list_table_engine olte_chk #(
  .DEPTH (DEPTH)
) u_olte_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_removed_i (rsp_o.removed_value),
  .rsp_found_i   (rsp_o.found_position),
  .rsp_count_i   (rsp_o.entry_count)
);

`default_nettype wire

### sim/olte_list_checker.sv
// ----------------------------------------------------------------------------
// olte_list_checker
// Watches the command and reply channels of the ordered list table engine,
// keeps its own copy of the list to predict each reply, and compares every
// reply field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olte_list_checker
  import olte_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  olte_req_if  req_i,
  olte_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned REPORT_CAP = 100;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] removed;
    logic [CNT_W-1:0]        found;
    logic [CNT_W-1:0]        count;
  } reply_t;

  logic signed [VAL_W-1:0] words [DEPTH];
  int unsigned             word_count;
  reply_t                  due_replies [$];
  int unsigned             reply_no;

  initial begin
    fail_count_o = 0;
    reply_no     = 0;
    word_count   = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count_o < REPORT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  // Applies one command to the shadow list and returns the reply it earns.
  function automatic reply_t list_apply(input logic [OP_W-1:0] op,
                                        input logic signed [VAL_W-1:0] val,
                                        input logic [POS_W-1:0] pos);
    reply_t      r;
    int unsigned slot;
    int unsigned i;
    r.status  = ST_OK;
    r.removed = '0;
    r.found   = '0;
    case (op)
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
        if (word_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_INS_AT && (pos == 0 || pos > word_count + 1)) begin
          r.status = ST_BADPOS;
        end else begin
          slot = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? word_count : pos - 1;
          for (i = word_count; i > slot; i--) words[i] = words[i-1];
          words[slot] = val;
          word_count++;
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AT: begin
        if (word_count == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_DEL_AT && (pos == 0 || pos > word_count)) begin
          r.status = ST_BADPOS;
        end else begin
          slot = (op == OP_DEL_HEAD) ? 0 : (op == OP_DEL_TAIL) ? word_count - 1 : pos - 1;
          r.removed = words[slot];
          for (i = slot; i + 1 < word_count; i++) words[i] = words[i+1];
          word_count--;
        end
      end
      OP_SEARCH: begin
        if (word_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < word_count; i++) begin
            if (words[i] == val) begin
              r.found  = CNT_W'(i + 1);
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      default: ;  // unused code: no change
    endcase
    r.count = CNT_W'(word_count);
    return r;
  endfunction

  task automatic check_reply();
    reply_t want;
    if (due_replies.size() == 0) begin
      report_mismatch($sformatf("reply %0d arrived with nothing outstanding", reply_no));
    end else begin
      want = due_replies.pop_front();
      if (rsp_i.status !== want.status)
        report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                  reply_no, rsp_i.status, want.status));
      if (rsp_i.removed_value !== want.removed)
        report_mismatch($sformatf("reply %0d removed_value %0d, want %0d",
                                  reply_no, rsp_i.removed_value, want.removed));
      if (rsp_i.found_position !== want.found)
        report_mismatch($sformatf("reply %0d found_position %0d, want %0d",
                                  reply_no, rsp_i.found_position, want.found));
      if (rsp_i.entry_count !== want.count)
        report_mismatch($sformatf("reply %0d entry_count %0d, want %0d",
                                  reply_no, rsp_i.entry_count, want.count));
    end
    reply_no++;
  endtask

  // Replies are taken before new commands: a reply can never belong to a
  // command accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_replies.delete();
      word_count = 0;
      pending_o <= 0;
    end else begin
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) check_reply();
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1)
        due_replies.push_back(list_apply(req_i.operation, req_i.value, req_i.position));
      pending_o <= due_replies.size();
    end
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives commands into the ordered list table engine: a directed opening
// on the corner cases, then phases of fill, drain, even and search-heavy
// traffic with bursty commands and a stalling reply side. The checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import olte_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned DRAIN_CYCLES = 40;         // above the worst delete latency
  localparam longint      TIMEOUT_NS   = 5_000_000;  // several times the slowest run

  // Operation code with no meaning; the engine must answer and change nothing.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_PROBE} traffic_e;
  typedef enum {RDY_OPEN, RDY_COIN, RDY_SPARSE, RDY_CYCLIC} ready_mode_e;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_cnt;
  int   burst_left;
  int   random_sent;

  // Small pool of values, reused so that searches hit and duplicates occur.
  logic signed [VAL_W-1:0] hot_values [8];

  olte_req_if req_ch ();
  olte_rsp_if rsp_ch ();

  ordered_list_table_engine #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VAL_W)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  olte_list_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_cnt)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sends one command. Between bursts the valid line may drop for a random
  // gap; inside a burst the next item follows on the very next cycle.
  // Valid gets at most one assignment per falling edge.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= val;
    req_ch.position  <= pos;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    burst_left--;
  endtask

  // Drops valid and holds off until every reply has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_cnt != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 60) return hot_values[3'($urandom_range(0, 7))];
    return $urandom;
  endfunction

  // One random command with the operation mix of the current phase.
  task automatic issue_random(input traffic_e mix);
    int              roll;
    int              ins_pct;
    int              del_pct;
    int              srch_pct;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    case (mix)
      MIX_FILL:  begin ins_pct = 70; del_pct = 15; srch_pct = 13; end
      MIX_DRAIN: begin ins_pct = 15; del_pct = 70; srch_pct = 13; end
      MIX_EVEN:  begin ins_pct = 40; del_pct = 40; srch_pct = 18; end
      default:   begin ins_pct = 25; del_pct = 25; srch_pct = 48; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct)
      op = OP_W'($urandom_range(int'(OP_INS_HEAD), int'(OP_INS_AT)));
    else if (roll < ins_pct + del_pct)
      op = OP_W'($urandom_range(int'(OP_DEL_HEAD), int'(OP_DEL_AT)));
    else if (roll < ins_pct + del_pct + srch_pct)
      op = OP_SEARCH;
    else
      op = OP_UNUSED;
    // Mostly near the live range of the list, sometimes anywhere in the field.
    pos = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 31))
                                      : POS_W'($urandom_range(0, DEPTH + 1));
    send_cmd(op, pick_value(), pos);
    random_sent++;
  endtask

  // Reply side: stall pattern changes from one random span to the next,
  // including stretches where ready never drops.
  initial begin
    ready_mode_e mode;
    int          span;
    int          tick;
    rsp_ch.ready = 1'b0;
    tick = 0;
    forever begin
      mode = ready_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 64);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RDY_OPEN:   rsp_ch.ready <= 1'b1;
          RDY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    rsp_ch.ready <= (tick % 3 != 0);
        endcase
        tick++;
      end
    end
  end

  // Main sequence
  initial begin
    traffic_e mix;
    int       block_len;
    int       block_no;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_INS_HEAD;
    req_ch.value     = '0;
    req_ch.position  = '0;
    burst_left       = 0;
    random_sent      = 0;
    rst_n            = 1'b0;
    hot_values[0] = 32'sh0000_0000;
    hot_values[1] = -32'sd1;
    hot_values[2] = 32'sh8000_0000;
    hot_values[3] = 32'sh7FFF_FFFF;
    for (int i = 4; i < 8; i++) hot_values[i] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening. Empty list first: every delete and the search
    // must say empty, and bad positions must be rejected.
    send_cmd(OP_SEARCH,   32'sd5,            5'd0);
    send_cmd(OP_DEL_HEAD, 32'sd0,            5'd0);
    send_cmd(OP_DEL_TAIL, 32'sd0,            5'd0);
    send_cmd(OP_DEL_AT,   32'sd0,            5'd1);
    send_cmd(OP_INS_AT,   32'sd7,            5'd0);   // position zero
    send_cmd(OP_INS_AT,   32'sd7,            5'd2);   // past length+1
    // Build [min, max, -1, 0] using every insert flavor, with the
    // positional append at length+1.
    send_cmd(OP_INS_AT,   32'sh7FFF_FFFF,    5'd1);
    send_cmd(OP_INS_HEAD, 32'sh8000_0000,    5'd0);
    send_cmd(OP_INS_TAIL, -32'sd1,           5'd31);
    send_cmd(OP_INS_AT,   32'sd0,            5'd4);
    send_cmd(OP_INS_AT,   32'sd1,            5'd31);  // bad position
    send_cmd(OP_SEARCH,   32'sh8000_0000,    5'd0);   // hit at head
    send_cmd(OP_SEARCH,   32'sd0,            5'd31);  // hit at tail
    send_cmd(OP_SEARCH,   32'sd12345,        5'd0);   // not present
    send_cmd(OP_DEL_AT,   32'sd0,            5'd0);   // bad position
    send_cmd(OP_DEL_AT,   32'sd0,            5'd5);   // past length
    send_cmd(OP_DEL_AT,   32'sd0,            5'd2);
    send_cmd(OP_UNUSED,   -32'sd1,           5'd31);  // ignored code
    send_cmd(OP_DEL_TAIL, 32'sd0,            5'd0);
    send_cmd(OP_DEL_HEAD, 32'sd0,            5'd0);
    send_cmd(OP_DEL_AT,   32'sd0,            5'd1);   // list empty again
    send_cmd(OP_UNUSED,   32'sd0,            5'd0);
    hold_until_drained();

    // Random phases. The first one fills the list so the full case shows
    // up early; later phases swing between full and empty.
    block_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mix       = (block_no == 0) ? MIX_FILL : traffic_e'($urandom_range(0, 3));
      block_len = (block_no == 0) ? 40 : $urandom_range(20, 50);
      repeat (block_len) issue_random(mix);
      block_no++;
      if (block_no % 8 == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d replies outstanding", pending_cnt);
    $display("== FAIL ==");
    $finish;
  end

endmodule
